[hdl/bcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared constants and helpers for the button chord detector
// Field widths, event codes and helpers (lowest-pressed encoder, count, mask).
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int NUM_BUTTONS = 6;

    localparam int LEVEL_W = 6;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int CODE_W  = 2;
    localparam int INDEX_W = 3;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [DELAY_W-1:0] SETTLE_DELAY_RESET = 16'd50;

    localparam logic [CODE_W-1:0] EV_NONE      = 2'd0;
    localparam logic [CODE_W-1:0] EV_BANK_DOWN = 2'd1;
    localparam logic [CODE_W-1:0] EV_BANK_UP   = 2'd2;
    localparam logic [CODE_W-1:0] EV_SINGLE    = 2'd3;

    // 1-based index of the lowest pressed button, 0 when none is pressed
    function automatic logic [INDEX_W-1:0] lowest_index(input logic [LEVEL_W-1:0] lv);
        logic [INDEX_W-1:0] idx;
        logic               found;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < LEVEL_W; i++)
        begin
            if (i < NUM_BUTTONS && lv[i] && !found)
            begin
                idx   = INDEX_W'(i + 1);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

    // number of pressed buttons within the active range
    function automatic logic [2:0] count_pressed(input logic [LEVEL_W-1:0] lv);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < LEVEL_W; i++)
        begin
            if (i < NUM_BUTTONS && lv[i])
                n = n + 3'd1;
        end
        return n;
    endfunction

    // drop levels of buttons beyond the active range
    function automatic logic [LEVEL_W-1:0] mask_levels(input logic [LEVEL_W-1:0] lv);
        logic [LEVEL_W-1:0] m;
        for (int i = 0; i < LEVEL_W; i++)
            m[i] = (i < NUM_BUTTONS) ? lv[i] : 1'b0;
        return m;
    endfunction

endpackage

[hdl/button_chord_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_detector_unit: pushbutton chord and single-press detector
// Settles button samples against a millisecond timestamp and reports
// bank-down, bank-up or single-press events, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   : button samples. tdata[5:0] button_levels, tdata[37:6] now_ms.
//   m_*   : one result per sample. tdata[1:0] event_code,
//           tdata[4:2] pressed_index.
//   cfg_* : writes settle_delay_ms (cfg_data); write only while idle.
// Each transfer on s_* lands in an input register; the phase machine
// then resolves it and loads the result register once that register
// is free, raising m_tvalid. One sample per cycle is sustained while
// m_* does not stall; the phase update (one 32-bit time subtract and
// compare) is combinational.
// A stall on m_* holds the result register; the input register then
// holds its sample and s_tready drops once both are occupied.
// Reset puts the phase machine in idle, clears the timestamp mark and
// loads a settle delay of 50 ms; no results are pending after reset.
// ----------------------------------------------------------------------------
module button_chord_detector_unit
    import bcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [5:0] button_levels, [37:6] now_ms

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [1:0] event_code, [4:2] pressed_index

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DELAY_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETTLE = 3'd1,
        PH_SINGLE = 3'd2,
        PH_PAIR   = 3'd3,
        PH_SPENT  = 3'd5
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic [DELAY_W-1:0]  delay_reg;

    logic                in_valid_reg;
    logic [LEVEL_W-1:0]  lv_reg;
    logic [TIME_W-1:0]   now_reg;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [INDEX_W-1:0]  index_reg, index_next;

    logic                out_free;
    logic                take;
    logic [LEVEL_W-1:0]  lv;
    logic [2:0]          cnt;
    logic [TIME_W-1:0]   delta;
    logic                elapsed;

    assign out_free  = !out_valid_reg || m_tready;
    assign take      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - CODE_W - INDEX_W){1'b0}}, index_reg, code_reg};

    assign lv      = mask_levels(lv_reg);
    assign cnt     = count_pressed(lv);
    assign delta   = now_reg - mark_reg;
    assign elapsed = delta > {{(TIME_W - DELAY_W){1'b0}}, delay_reg};

    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        code_next  = EV_NONE;
        index_next = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (cnt != 3'd0)
                begin
                    phase_next = PH_SETTLE;
                    mark_next  = now_reg;
                end
            end
            PH_SETTLE:
            begin
                // a fresh mark restarts the settle delay for later samples
                if (elapsed && cnt == 3'd1)
                begin
                    phase_next = PH_SPENT;
                    mark_next  = now_reg;
                    code_next  = EV_SINGLE;
                    index_next = lowest_index(lv);
                end
                else if (elapsed && cnt == 3'd2)
                begin
                    mark_next = now_reg;
                    if (lv[0] && lv[1])
                    begin
                        phase_next = PH_SPENT;
                        code_next  = EV_BANK_DOWN;
                    end
                    else if (lv[1] && lv[2])
                    begin
                        phase_next = PH_SPENT;
                        code_next  = EV_BANK_UP;
                    end
                    else
                        phase_next = PH_PAIR;
                end
            end
            PH_SINGLE:
            begin
                phase_next = PH_SPENT;
                code_next  = EV_SINGLE;
                index_next = lowest_index(lv);
            end
            PH_PAIR:
            begin
                if (lv[0] && lv[1])
                begin
                    phase_next = PH_SPENT;
                    code_next  = EV_BANK_DOWN;
                end
                else if (lv[1] && lv[2])
                begin
                    phase_next = PH_SPENT;
                    code_next  = EV_BANK_UP;
                end
            end
            default:
            begin
                // spent: wait for full release after the delay
                if (elapsed && cnt == 3'd0)
                    phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mark_reg      <= '0;
            delay_reg     <= SETTLE_DELAY_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                delay_reg <= cfg_data;

            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (take)
            begin
                phase_reg <= phase_next;
                mark_reg  <= mark_next;
            end

            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            lv_reg  <= s_tdata[LEVEL_W-1:0];
            now_reg <= s_tdata[LEVEL_W +: TIME_W];
        end
        if (take)
        begin
            code_reg  <= code_next;
            index_reg <= index_next;
        end
    end

endmodule
